// ----- sv/kscw_pkg.sv -----
// Shared types and constants for the k-step minimum cost walk block.
// This file depends on nothing else. Every other file in the project but kscw_ram imports it.
`default_nettype none
package kscw_pkg;

  // Field widths and fixed values.
  localparam int HEIGHT_W = 16;
  localparam int COST_W   = 32;
  localparam int CFG_W    = 5;
  localparam logic [COST_W-1:0] COST_MAX   = {COST_W{1'b1}};
  localparam logic [CFG_W-1:0]  JUMP_RESET = 5'd2;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_WRITE
  } kscw_state_t;

  // Commands that the controller sends to the datapath.
  typedef struct packed {
    logic load;    // take the input item and set up the window scan
    logic rd;      // issue one window read
    logic commit;  // store the new stone and present the result
  } kscw_cmd_t;

  // Status that the datapath reports to the controller.
  typedef struct packed {
    logic span_zero;  // the incoming stone needs no window scan
    logic last_rd;    // the read issued this cycle is the last one
    logic out_free;   // the output register can take a result this cycle
  } kscw_status_t;

endpackage
`default_nettype wire

// ----- sv/kscw_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// This file has no dependencies.
`default_nettype none
module kscw_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/kscw_ctrl.sv -----
// Controller state machine for the k-step minimum cost walk block.
// Depends on kscw_pkg for its state, command and status types.
`default_nettype none
module kscw_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire kscw_pkg::kscw_status_t status,
  output kscw_pkg::kscw_cmd_t         cmd
);
  import kscw_pkg::*;

  kscw_state_t state;
  kscw_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.span_zero ? S_WRITE : S_READ;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        if (status.last_rd) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last read's data is folded into the minimum in this cycle.
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/kscw_dp.sv -----
// Datapath for the k-step minimum cost walk block: window RAM, scan pointers,
// the shared add-compare unit, and the output register.
// Depends on kscw_pkg and kscw_ram.
`default_nettype none
module kscw_dp #(
  parameter int MAX_JUMP = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [kscw_pkg::HEIGHT_W-1:0] height,
  input  wire logic                          start_new,
  input  wire logic                          cfg_we,
  input  wire logic [kscw_pkg::CFG_W-1:0]    cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [kscw_pkg::COST_W-1:0]   min_energy,
  input  wire kscw_pkg::kscw_cmd_t           cmd,
  output kscw_pkg::kscw_status_t             status
);
  import kscw_pkg::*;

  localparam int AW = $clog2(MAX_JUMP);
  localparam int SW = $clog2(MAX_JUMP + 1);
  localparam int EW = HEIGHT_W + COST_W;
  localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_JUMP - 1);
  localparam logic [SW-1:0] SEEN_MAX  = SW'(MAX_JUMP);

  logic [CFG_W-1:0]    max_jump;
  logic [SW-1:0]       stones_seen;
  logic [AW-1:0]       newest_addr;
  logic [AW-1:0]       rd_addr;
  logic [SW-1:0]       rd_cnt;
  logic                rd_valid;
  logic                fresh;
  logic [HEIGHT_W-1:0] cur_height;
  logic [COST_W-1:0]   best;

  logic [SW-1:0]       jump_lim;
  logic [SW-1:0]       span;
  logic                fresh_in;
  logic [AW-1:0]       wr_addr;
  logic [EW-1:0]       rd_data;
  logic [HEIGHT_W-1:0] prev_height;
  logic [COST_W-1:0]   prev_cost;
  logic [HEIGHT_W-1:0] diff;
  logic [COST_W:0]     sum;
  logic [COST_W-1:0]   sum_sat;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_jump <= JUMP_RESET;
    end else if (cfg_we) begin
      max_jump <= cfg_data;
    end
  end

  // Jump limit clamped to 1..MAX_JUMP, then to the stones seen so far.
  always_comb begin
    if (32'(max_jump) > 32'(MAX_JUMP)) begin
      jump_lim = SEEN_MAX;
    end else if (max_jump == '0) begin
      jump_lim = SW'(1);
    end else begin
      jump_lim = SW'(max_jump);
    end
    span     = (jump_lim > stones_seen) ? stones_seen : jump_lim;
    fresh_in = start_new || (stones_seen == '0);
  end

  // Next write slot follows the newest entry with wraparound.
  assign wr_addr = (newest_addr == ADDR_LAST) ? '0 : newest_addr + AW'(1);

  // Window storage: height in the upper bits, cost in the lower bits.
  kscw_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_JUMP)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (wr_addr),
    .wdata ({cur_height, best}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Shared add-compare unit: earlier cost plus the height difference, saturated.
  always_comb begin
    prev_height = rd_data[EW-1:COST_W];
    prev_cost   = rd_data[COST_W-1:0];
    diff        = (cur_height >= prev_height) ? cur_height - prev_height
                                              : prev_height - cur_height;
    sum         = {1'b0, prev_cost} + {{(COST_W + 1 - HEIGHT_W){1'b0}}, diff};
    sum_sat     = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
  end

  // Scan control, running minimum and window bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      stones_seen <= '0;
      newest_addr <= '0;
      rd_valid    <= 1'b0;
    end else begin
      rd_valid <= cmd.rd;
      if (cmd.commit) begin
        newest_addr <= wr_addr;
        if (fresh) begin
          stones_seen <= SW'(1);
        end else if (stones_seen < SEEN_MAX) begin
          stones_seen <= stones_seen + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_height <= height;
      fresh      <= fresh_in;
      best       <= fresh_in ? '0 : COST_MAX;
      rd_addr    <= newest_addr;
      rd_cnt     <= span;
    end else begin
      if (cmd.rd) begin
        rd_addr <= (rd_addr == '0) ? ADDR_LAST : rd_addr - AW'(1);
        rd_cnt  <= rd_cnt - SW'(1);
      end
      if (rd_valid && (sum_sat < best)) begin
        best <= sum_sat;
      end
    end
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      min_energy <= best;
    end
  end

  // Status toward the controller.
  always_comb begin
    status.span_zero = fresh_in;
    status.last_rd   = (rd_cnt == SW'(1));
    status.out_free  = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

// ----- sv/k_step_min_cost_walk.sv -----
// k_step_min_cost_walk: streams stone heights and returns, for each stone, the
// least energy to reach it from the first stone of its sequence.
// Input channel: in_valid/in_ready with height and start_new; a transfer takes
//   one stone. start_new marks the first stone of a sequence; that stone, and
//   the first stone after reset, yields min_energy 0.
// Output channel: out_valid/out_ready with min_energy, one result per stone,
//   in input order. Costs saturate at the 32-bit maximum.
// Configuration: cfg_we writes cfg_data into max_jump (reset value 2). A value
//   of 0 acts as 1, a value above MAX_JUMP acts as MAX_JUMP. Write only while
//   the block is idle.
// Timing: each stone's result follows a scan of span earlier stones, where span
//   is the jump limit cut to the stones seen in the sequence, at most MAX_JUMP;
//   a first stone needs no scan. The next stone is taken only once the last
//   one's result is stored; the single read port of the window RAM visits one
//   earlier stone per cycle.
// Stalls: a finished result waits in the output register; the next stone is
//   accepted meanwhile and its scan runs, then it waits until the register
//   frees. Reset (rst, synchronous) empties the window and the output and
//   restores max_jump; no clearing pass is needed.
// Depends on kscw_pkg, kscw_ctrl, kscw_dp and kscw_ram.
`default_nettype none
module k_step_min_cost_walk #(
  parameter int MAX_JUMP = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [kscw_pkg::HEIGHT_W-1:0] height,
  input  wire logic                          start_new,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [kscw_pkg::COST_W-1:0]   min_energy,
  input  wire logic                          cfg_we,
  input  wire logic [kscw_pkg::CFG_W-1:0]    cfg_data
);
  import kscw_pkg::*;

  kscw_cmd_t    cmd;
  kscw_status_t status;

  // Sequencer.
  kscw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Window storage and arithmetic.
  kscw_dp #(
    .MAX_JUMP (MAX_JUMP)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .height     (height),
    .start_new  (start_new),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .min_energy (min_energy),
    .cmd        (cmd),
    .status     (status)
  );

endmodule
`default_nettype wire

// ----- sv/kscw_checker.sv -----
// Port-level checks for k_step_min_cost_walk, attached by a bind statement.
// Depends on kscw_pkg for field widths.
`default_nettype none
module kscw_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [kscw_pkg::COST_W-1:0] min_energy
);
  import kscw_pkg::*;

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(min_energy))
    else $error("result changed or dropped while stalled");

  // One stone is in work at a time, so two input transfers never abut.
  a_in_spacing: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input transfer in back-to-back cycles");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result pending after reset");

endmodule

bind k_step_min_cost_walk kscw_checker u_kscw_checker (.*);
`default_nettype wire
